// File: design/lpm_pkg.sv
// Shared types, constants and a helper function for the IPv4 longest-prefix-match core.
// No dependencies; imported by lpm_match and ipv4_lpm_forwarding_core.
package lpm_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 64;
    localparam int PORT_COUNT  = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int IP_W   = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 4;
    localparam int TTL_W  = 8;
    localparam int STAT_W = 3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(IP_W);
    localparam logic [IP_W-1:0]  ALL_ONES = 32'hFFFF_FFFF;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FORWARDED = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_TTL_DROP  = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_NO_ROUTE  = 3'd4;

    // Mode codes
    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_FORWARD = 1'b1;

    // One routing table entry as stored in the RAM
    typedef struct packed {
        logic [IP_W-1:0]   prefix;
        logic [LEN_W-1:0]  len;
        logic              has_gw;
        logic [IP_W-1:0]   gw;
        logic [PORT_W-1:0] port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Best match so far, from the match tracker to the control
    typedef struct packed {
        logic              found;
        logic              has_gw;
        logic [IP_W-1:0]   gw;
        logic [PORT_W-1:0] port;
    } match_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Network mask for a prefix length (length already saturated to 32)
    function automatic logic [IP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [IP_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else if (len >= MAX_LEN) begin
            m = ALL_ONES;
        end else begin
            m = ~(ALL_ONES >> len);
        end
        return m;
    endfunction

endpackage

// File: design/ipv4_lpm_forwarding_core.sv
// Top level of the IPv4 longest-prefix-match forwarding core: control, table RAM, output register.
// Depends on lpm_pkg, lpm_ram and lpm_match.
//
//  channel | signals                  | direction | contents
//  --------+--------------------------+-----------+-------------------------------------------
//  in      | in_valid / in_ready      | into core | mode, route and datagram fields
//  out     | out_valid / out_ready    | out       | status, port_out, gateway_out, hops_left_out
//
// An add request or a TTL drop goes from acceptance through FINISH into the output register.
// A forward request scans the table one entry per cycle through the RAM read port,
// reading entries 0 to entry_count - 1; a forward with an empty table skips the scan.
// One request is in work at a time; the next is accepted once the result sits in the
// output register, even while that result still waits for out_ready.
// Reset clears the entry count and the control state; table contents need no clearing.
module ipv4_lpm_forwarding_core
    import lpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [IP_W-1:0]   route_prefix_in,
    input  logic [LEN_W-1:0]  prefix_len_in,
    input  logic              has_gateway,
    input  logic [IP_W-1:0]   gateway_in,
    input  logic [PORT_W-1:0] port_in,
    input  logic [IP_W-1:0]   dest_addr,
    input  logic [TTL_W-1:0]  hops_left_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [PORT_W-1:0] port_out,
    output logic [IP_W-1:0]   gateway_out,
    output logic [TTL_W-1:0]  hops_left_out
);

    localparam logic [PORT_W+8:0] PORT_LIMIT = (PORT_W + 9)'(PORT_COUNT);
    localparam logic [PORT_W-1:0] PORT_MAX   = PORT_W'(PORT_COUNT - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(TABLE_DEPTH);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 issuing_reg, issuing_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 scan_reg, scan_next;
    logic [STAT_W-1:0]    pend_status_reg, pend_status_next;
    logic [IP_W-1:0]      dest_reg, dest_next;
    logic [TTL_W-1:0]     ttl_reg, ttl_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [PORT_W-1:0]    port_reg, port_next;
    logic [IP_W-1:0]      gw_reg, gw_next;
    logic [TTL_W-1:0]     hops_reg, hops_next;

    logic                 in_accept;
    logic                 table_full;
    logic                 ram_we;
    logic                 ram_re;
    entry_t               wr_entry;
    entry_t               rd_entry;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 match_clear;
    match_t               best;
    logic                 out_load;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign table_full = (count_reg == CNT_FULL);
    assign out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // New table entry, with length and port saturated
    always_comb
    begin
        wr_entry.prefix = route_prefix_in;
        wr_entry.len    = (prefix_len_in > MAX_LEN) ? MAX_LEN : prefix_len_in;
        wr_entry.has_gw = has_gateway;
        wr_entry.gw     = gateway_in;
        wr_entry.port   = ((PORT_W + 9)'(port_in) >= PORT_LIMIT) ? PORT_MAX : port_in;
    end

    // Table write happens at acceptance; the scan reads only from the next cycle on
    assign ram_we      = in_accept && (mode == MODE_ADD) && !table_full;
    assign ram_re      = (state_reg == ST_SCAN) && issuing_reg;
    assign rd_entry    = entry_t'(rd_data);
    assign match_clear = in_accept;

    lpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    lpm_match u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (match_clear),
        .entry_valid (rd_valid_reg),
        .entry       (rd_entry),
        .dest        (dest_reg),
        .best        (best)
    );

    // Sequencer: accept, scan, deliver
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        issuing_next     = issuing_reg;
        rd_valid_next    = ram_re;
        scan_next        = scan_reg;
        pend_status_next = pend_status_reg;
        dest_next        = dest_reg;
        ttl_next         = ttl_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    dest_next = dest_addr;
                    ttl_next  = hops_left_in;
                    scan_next = 1'b0;
                    idx_next  = '0;
                    if (mode == MODE_ADD)
                    begin
                        if (table_full)
                        begin
                            pend_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            pend_status_next = STATUS_ADDED;
                            count_next       = count_reg + 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    else if (hops_left_in <= TTL_W'(1))
                    begin
                        pend_status_next = STATUS_TTL_DROP;
                        state_next       = ST_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_status_next = STATUS_NO_ROUTE;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        scan_next    = 1'b1;
                        issuing_next = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issuing_reg)
                begin
                    if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (rd_valid_reg)
                begin
                    // last entry is folded into the tracker at this edge
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register contents
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        port_next      = port_reg;
        gw_next        = gw_reg;
        hops_next      = hops_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (scan_reg && best.found)
            begin
                status_next = STATUS_FORWARDED;
                port_next   = best.port;
                gw_next     = best.has_gw ? best.gw : dest_reg;
                hops_next   = ttl_reg - 1'b1;
            end
            else
            begin
                status_next = scan_reg ? STATUS_NO_ROUTE : pend_status_reg;
                port_next   = '0;
                gw_next     = '0;
                hops_next   = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issuing_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            scan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issuing_reg   <= issuing_next;
            rd_valid_reg  <= rd_valid_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        pend_status_reg <= pend_status_next;
        dest_reg        <= dest_next;
        ttl_reg         <= ttl_next;
        status_reg      <= status_next;
        port_reg        <= port_next;
        gw_reg          <= gw_next;
        hops_reg        <= hops_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign port_out      = port_reg;
    assign gateway_out   = gw_reg;
    assign hops_left_out = hops_reg;

    // The entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count beyond table depth");

    // The count changes only through an accepted add request
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && (mode == MODE_ADD)) |=> $stable(count_reg))
        else $error("entry count changed without an add request");

    // A finished result waits in FINISH while the output register is still occupied
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && !out_ready |=> state_reg == ST_FINISH)
        else $error("result dropped while output register busy");

    // A forwarded datagram always leaves with a TTL of at least one
    a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == STATUS_FORWARDED) |-> hops_reg != '0)
        else $error("forwarded datagram with zero TTL");

endmodule

// File: design/lpm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/lpm_match.sv
// Best-match tracker: compares each entry read from the table against the destination.
// Depends on lpm_pkg.
module lpm_match
    import lpm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            entry_valid,
    input  entry_t          entry,
    input  logic [IP_W-1:0] dest,
    output match_t          best
);

    logic               found_reg, found_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic               has_gw_reg, has_gw_next;
    logic [IP_W-1:0]    gw_reg, gw_next;
    logic [PORT_W-1:0]  port_reg, port_next;
    logic               hit;
    logic               take;

    // Prefix compare and longest-length selection; ties keep the earlier entry
    always_comb
    begin
        hit  = ((dest ^ entry.prefix) & len_mask(entry.len)) == '0;
        take = entry_valid && hit && (!found_reg || (entry.len > best_len_reg));

        found_next    = found_reg;
        best_len_next = best_len_reg;
        has_gw_next   = has_gw_reg;
        gw_next       = gw_reg;
        port_next     = port_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next    = 1'b1;
            best_len_next = entry.len;
            has_gw_next   = entry.has_gw;
            gw_next       = entry.gw;
            port_next     = entry.port;
        end
    end

    // Found flag is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // Best entry payload
    always_ff @(posedge clk)
    begin
        best_len_reg <= best_len_next;
        has_gw_reg   <= has_gw_next;
        gw_reg       <= gw_next;
        port_reg     <= port_next;
    end

    assign best.found  = found_reg;
    assign best.has_gw = has_gw_reg;
    assign best.gw     = gw_reg;
    assign best.port   = port_reg;

endmodule
